>>> design/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg - shared types and constants of the lidar packet deframer
// Holds the framing constants, the frame mode codes and the reading record.
// ----------------------------------------------------------------------------
package lpd_pkg;

  localparam logic [7:0] START_BYTE   = 8'hFA;
  localparam logic [7:0] PKT_FIRST    = 8'hA0;
  localparam logic [7:0] PKT_LAST     = 8'hF9;
  localparam logic [7:0] RANGE_HI_MSK = 8'h3F;

  // Frame mode: one-hot
  typedef enum logic [4:0] {
    MODE_HUNT   = 5'b00001,
    MODE_PKT    = 5'b00010,
    MODE_SPD_LO = 5'b00100,
    MODE_SPD_HI = 5'b01000,
    MODE_READ   = 5'b10000
  } mode_t;

  // One decoded reading
  typedef struct packed {
    logic [8:0]  angle_index;
    logic [13:0] range_value;
    logic [15:0] strength;
    logic [15:0] rotation_speed;
  } reading_t;

endpackage

>>> design/lidar_packet_deframer.sv
// ----------------------------------------------------------------------------
// lidar_packet_deframer - serial packet deframer for a rotating range sensor
// Turns the sensor byte stream into one decoded reading per four data bytes.
// ----------------------------------------------------------------------------
// Feed the received serial bytes in order, one transaction per byte; the block
// takes a byte every clock cycle unless the input is stalled. It hunts for the
// start byte 0xFA, checks that the next byte is a packet number 0xA0..0xF9
// (otherwise drops it and resumes hunting), takes the little-endian speed word
// and then four readings of four bytes. On the last byte of each reading it
// gives one result transaction: angle slot 0..359, 14-bit range with the flag
// bits cleared, 16-bit strength and the packet speed word. Checksum bytes are
// not verified; hunting skips them, and a start byte inside a packet is data.
// A result is presented once its last byte has passed through the input
// register and the result register has captured the reading, which the
// receiver can then take. Throughput is one byte per cycle, limited only by
// the result register: while a result is stalled, the bytes ahead of the one
// that would complete the next reading keep flowing; once that byte reaches
// the input register, the input stalls until the result register frees.
// ----------------------------------------------------------------------------
module lidar_packet_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [8:0]  out_angle_index,
  output logic [13:0] out_range_value,
  output logic [15:0] out_strength,
  output logic [15:0] out_rotation_speed
);

  logic              byte_vld;
  logic [7:0]        byte_dat;
  logic              take;
  logic              emit;
  logic              out_ready;
  lpd_pkg::reading_t reading;
  lpd_pkg::reading_t out_data;

  // Input register: hold the incoming byte until the framer consumes it
  lpd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .take       (take),
    .byte_vld   (byte_vld),
    .byte_dat   (byte_dat)
  );

  // Framer: advance the packet position and assemble the reading
  lpd_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_vld  (byte_vld),
    .byte_dat  (byte_dat),
    .out_ready (out_ready),
    .take      (take),
    .emit      (emit),
    .reading   (reading)
  );

  // Result register: decouple the receiver's stall from the framer
  lpd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit      (emit),
    .take      (take),
    .reading   (reading),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_angle_index    = out_data.angle_index;
  assign out_range_value    = out_data.range_value;
  assign out_strength       = out_data.strength;
  assign out_rotation_speed = out_data.rotation_speed;

endmodule

>>> design/lpd_in_reg.sv
// ----------------------------------------------------------------------------
// lpd_in_reg - input byte register
// Captures one byte transaction and holds it until the framer consumes it.
// ----------------------------------------------------------------------------
module lpd_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       take,
  output logic       byte_vld,
  output logic [7:0] byte_dat
);

  logic       vld_r, vld_nxt;
  logic [7:0] dat_r, dat_nxt;

  // Accept when empty or when the held byte leaves this cycle
  assign in_stall = vld_r && !take;

  always_comb begin
    vld_nxt = vld_r;
    dat_nxt = dat_r;
    if (!in_stall) begin
      vld_nxt = in_valid;
      if (in_valid) begin
        dat_nxt = in_rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    dat_r <= dat_nxt;
  end

  assign byte_vld = vld_r;
  assign byte_dat = dat_r;

endmodule

>>> design/lpd_frame.sv
// ----------------------------------------------------------------------------
// lpd_frame - packet framing state and reading assembly
// Tracks the position in the packet and builds a reading on its last byte.
// ----------------------------------------------------------------------------
module lpd_frame (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_vld,
  input  logic [7:0]        byte_dat,
  input  logic              out_ready,
  output logic              take,
  output logic              emit,
  output lpd_pkg::reading_t reading
);

  lpd_pkg::mode_t mode_r, mode_nxt;
  logic [3:0]     rd_cnt_r, rd_cnt_nxt;
  logic [6:0]     pkt_r, pkt_nxt;
  logic [15:0]    speed_r, speed_nxt;
  logic [23:0]    latch_r, latch_nxt;
  logic [7:0]     pkt_diff;
  logic           pkt_ok;

  assign pkt_diff = byte_dat - lpd_pkg::PKT_FIRST;
  assign pkt_ok   = (byte_dat >= lpd_pkg::PKT_FIRST) && (byte_dat <= lpd_pkg::PKT_LAST);

  // A byte completes a reading on the fourth byte of each group
  assign emit = byte_vld && (mode_r == lpd_pkg::MODE_READ) && (rd_cnt_r[1:0] == 2'd3);
  // Bytes that give no result pass even while the output is stalled
  assign take = byte_vld && (!emit || out_ready);

  always_comb begin
    reading.angle_index    = {pkt_r, rd_cnt_r[3:2]};
    reading.range_value    = {latch_r[13:8], latch_r[7:0]};
    reading.strength       = {byte_dat, latch_r[23:16]};
    reading.rotation_speed = speed_r;
  end

  always_comb begin
    mode_nxt   = mode_r;
    rd_cnt_nxt = rd_cnt_r;
    pkt_nxt    = pkt_r;
    speed_nxt  = speed_r;
    latch_nxt  = latch_r;
    if (take) begin
      case (mode_r)
        lpd_pkg::MODE_PKT: begin
          if (pkt_ok) begin
            pkt_nxt  = pkt_diff[6:0];
            mode_nxt = lpd_pkg::MODE_SPD_LO;
          end else begin
            mode_nxt = lpd_pkg::MODE_HUNT;
          end
        end
        lpd_pkg::MODE_SPD_LO: begin
          speed_nxt = {8'h00, byte_dat};
          mode_nxt  = lpd_pkg::MODE_SPD_HI;
        end
        lpd_pkg::MODE_SPD_HI: begin
          speed_nxt  = {byte_dat, speed_r[7:0]};
          rd_cnt_nxt = 4'd0;
          mode_nxt   = lpd_pkg::MODE_READ;
        end
        lpd_pkg::MODE_READ: begin
          case (rd_cnt_r[1:0])
            2'd0:    latch_nxt = {16'h0000, byte_dat};
            2'd1:    latch_nxt = {8'h00, byte_dat & lpd_pkg::RANGE_HI_MSK, latch_r[7:0]};
            2'd2:    latch_nxt = {byte_dat, latch_r[15:0]};
            default: latch_nxt = latch_r;
          endcase
          rd_cnt_nxt = rd_cnt_r + 4'd1;
          if (rd_cnt_r == 4'd15) begin
            mode_nxt = lpd_pkg::MODE_HUNT;
          end
        end
        default: begin
          mode_nxt = (byte_dat == lpd_pkg::START_BYTE) ? lpd_pkg::MODE_PKT
                                                        : lpd_pkg::MODE_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= lpd_pkg::MODE_HUNT;
      rd_cnt_r <= 4'd0;
      pkt_r    <= 7'd0;
      speed_r  <= 16'd0;
      latch_r  <= 24'd0;
    end else begin
      mode_r   <= mode_nxt;
      rd_cnt_r <= rd_cnt_nxt;
      pkt_r    <= pkt_nxt;
      speed_r  <= speed_nxt;
      latch_r  <= latch_nxt;
    end
  end

endmodule

>>> design/lpd_out_reg.sv
// ----------------------------------------------------------------------------
// lpd_out_reg - result register
// Holds one reading transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module lpd_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              emit,
  input  logic              take,
  input  lpd_pkg::reading_t reading,
  output logic              out_ready,
  output logic              out_valid,
  input  logic              out_stall,
  output lpd_pkg::reading_t out_data
);

  logic              vld_r, vld_nxt;
  lpd_pkg::reading_t dat_r, dat_nxt;

  assign out_ready = !vld_r || !out_stall;

  always_comb begin
    vld_nxt = vld_r;
    dat_nxt = dat_r;
    if (out_ready) begin
      vld_nxt = emit && take;
      if (emit && take) begin
        dat_nxt = reading;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    dat_r <= dat_nxt;
  end

  assign out_valid = vld_r;
  assign out_data  = dat_r;

endmodule

>>> design/lpd_checker.sv
// ----------------------------------------------------------------------------
// lpd_checker - port-level checks for the lidar packet deframer
// Watches the result channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
module lpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [8:0]  out_angle_index,
  input logic [13:0] out_range_value,
  input logic [15:0] out_strength,
  input logic [15:0] out_rotation_speed
);

  // Hold a stalled result transaction
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_angle_index) && $stable(out_range_value)
      && $stable(out_strength) && $stable(out_rotation_speed))
    else $error("stalled result changed");

  // Angle slot stays within one turn
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_angle_index <= 9'd359)
    else $error("angle slot out of range");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind lidar_packet_deframer lpd_checker u_lpd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_angle_index    (out_angle_index),
  .out_range_value    (out_range_value),
  .out_strength       (out_strength),
  .out_rotation_speed (out_rotation_speed)
);
